// ===== rtl/core/gba_pkg.sv =====
// shared types, widths and codes of the grouped bitmap allocator
package gba_pkg;

    localparam int NUM_W       = 19;
    localparam int GRP_IN_W    = 5;
    localparam int OP_W        = 2;
    localparam int FIG_W       = 14;
    localparam int FT_W        = 19;
    localparam int IPG_CFG_W   = 14;
    localparam int GCNT_CFG_W  = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 14;
    localparam int WORD_BITS   = 32;
    localparam int WORD_SHIFT  = 5;

    localparam int DEF_GROUPS     = 32;
    localparam int DEF_GROUP_BITS = 8192;

    localparam logic [IPG_CFG_W-1:0]  DEF_IPG  = 14'd8192;
    localparam logic [GCNT_CFG_W-1:0] DEF_GCNT = 6'd32;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND    = 2'd2;
    localparam logic [OP_W-1:0] OP_MARK    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_IPG  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GCNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [GRP_IN_W-1:0] group;
        logic [NUM_W-1:0]    item_number;
    } cmd_item_t;

    typedef struct packed {
        logic                status;
        logic [NUM_W-1:0]    number_out;
        logic [GRP_IN_W-1:0] group_out;
        logic [FIG_W-1:0]    free_in_group;
        logic [FT_W-1:0]     free_total;
    } res_item_t;

endpackage

// ===== rtl/core/gba_mod_unit.sv =====
// iterative restoring remainder unit, one dividend bit per cycle
module gba_mod_unit #(
    parameter int IPG_W = $clog2(gba_pkg::DEF_GROUP_BITS + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [gba_pkg::NUM_W-1:0]  dividend,
    input  logic [IPG_W-1:0]           divisor,
    output logic                       done,
    output logic [IPG_W-1:0]           rem
);

    localparam int CNT_W = $clog2(gba_pkg::NUM_W);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [gba_pkg::NUM_W-1:0] quo_reg;
    logic [IPG_W-1:0]          rem_reg;
    logic [IPG_W:0]            partial;
    logic [IPG_W-1:0]          rem_next;

    // shift in the next dividend bit, subtract once if it fits
    always_comb
    begin
        partial = {rem_reg, quo_reg[gba_pkg::NUM_W-1]};
        if (partial >= {1'b0, divisor})
        begin
            rem_next = IPG_W'(partial - {1'b0, divisor});
        end
        else
        begin
            rem_next = IPG_W'(partial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_reg << 1;
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(gba_pkg::NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < divisor)
        else $error("remainder not below divisor");

endmodule

// ===== rtl/core/gba_bitmap_ram.sv =====
// bitmap word store, one write and one registered read port
module gba_bitmap_ram #(
    parameter int ADDR_W = $clog2(gba_pkg::DEF_GROUPS)
                         + $clog2(gba_pkg::DEF_GROUP_BITS / gba_pkg::WORD_BITS)
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [ADDR_W-1:0]                 waddr,
    input  logic [gba_pkg::WORD_BITS-1:0]     wdata,
    input  logic [ADDR_W-1:0]                 raddr,
    output logic [gba_pkg::WORD_BITS-1:0]     rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [gba_pkg::WORD_BITS-1:0] mem [0:DEPTH-1];
    logic [gba_pkg::WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/gba_seq.sv =====
// operation sequencer: bitmap scan, read-modify-write, counters, group search
module gba_seq #(
    parameter int GROUPS     = gba_pkg::DEF_GROUPS,
    parameter int GROUP_BITS = gba_pkg::DEF_GROUP_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  gba_pkg::cmd_item_t         cmd,
    output logic                       res_valid,
    input  logic                       res_stall,
    output gba_pkg::res_item_t         res,
    input  logic [$clog2(GROUP_BITS+1)-1:0]              eff_ipg,
    input  logic [$clog2(GROUPS+1)-1:0]                  eff_groups,
    input  logic                                         base,
    input  logic [$clog2(GROUPS*GROUP_BITS+1)-1:0]       cap,
    input  logic [$clog2(GROUP_BITS/gba_pkg::WORD_BITS)-1:0] last_word,
    input  logic [gba_pkg::WORD_BITS-1:0]                last_mask
);

    localparam int WPG      = GROUP_BITS / gba_pkg::WORD_BITS;
    localparam int WIDX_W   = $clog2(WPG);
    localparam int GRP_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int ADDR_W   = GRP_W + WIDX_W;
    localparam int IPG_W    = $clog2(GROUP_BITS + 1);
    localparam int IDX_W    = WIDX_W + gba_pkg::WORD_SHIFT;
    localparam int GCNT_W   = $clog2(GROUPS + 1);
    localparam int TOT_W    = $clog2(GROUPS * GROUP_BITS + 1);
    localparam int GU_DEPTH = 1 << GRP_W;
    localparam int PROD_W   = gba_pkg::GRP_IN_W + IPG_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int WB       = gba_pkg::WORD_BITS;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_MOD,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_FIND,
        ST_CNT,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t                          state_reg, state_next;
    logic [ADDR_W-1:0]               clr_cnt_reg, clr_cnt_next;
    logic [gba_pkg::OP_W-1:0]        op_reg, op_next;
    logic [gba_pkg::GRP_IN_W-1:0]    g_reg, g_next;
    logic [WIDX_W-1:0]               w_reg, w_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [GCNT_W-1:0]               k_reg, k_next;
    logic                            set_reg, set_next;
    logic                            status_reg, status_next;
    logic [gba_pkg::GRP_IN_W-1:0]    gout_reg, gout_next;
    logic [TOT_W-1:0]                total_reg, total_next;
    logic                            res_valid_reg, res_valid_next;
    gba_pkg::res_item_t              res_reg, res_next;
    logic [PROD_W-1:0]               prod_reg;

    // bitmap port
    logic                bm_we;
    logic [ADDR_W-1:0]   bm_waddr;
    logic [WB-1:0]       bm_wdata;
    logic [ADDR_W-1:0]   bm_raddr;
    logic [WB-1:0]       bm_rdata;

    // group used counters
    logic [IPG_W-1:0]    gu_mem [0:GU_DEPTH-1];
    logic [IPG_W-1:0]    gu_rdata_reg;
    logic                gu_we;
    logic [GRP_W-1:0]    gu_waddr;
    logic [IPG_W-1:0]    gu_wdata;
    logic [GRP_W-1:0]    gu_raddr;

    logic                mod_start;
    logic                mod_done;
    logic [IPG_W-1:0]    mod_rem;
    logic [gba_pkg::NUM_W-1:0] mod_dividend;

    logic [WB-1:0]       vmask;
    logic [WB-1:0]       free_bits;
    logic                found;
    logic [gba_pkg::WORD_SHIFT-1:0] pos;
    logic [WB-1:0]       idx_bit_mask;
    logic [IPG_W:0]      used_inc;
    logic [IPG_W-1:0]    used_new;
    logic [TOT_W:0]      tot_inc;
    logic [TOT_W-1:0]    tot_new;
    logic                g_ok_in;
    logic [IPG_W-1:0]    fig_full;
    logic [TOT_W-1:0]    ft_full;
    logic [SUM_W-1:0]    nsum;

    gba_bitmap_ram #(
        .ADDR_W (ADDR_W)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    assign mod_dividend = cmd.item_number - gba_pkg::NUM_W'(base);

    gba_mod_unit #(
        .IPG_W (IPG_W)
    ) u_mod_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .divisor  (eff_ipg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // lowest free bit of the current word, bits past the group size count as used
    always_comb
    begin
        vmask     = (w_reg == last_word) ? last_mask : '1;
        free_bits = ~bm_rdata & vmask;
        found     = |free_bits;
        pos       = '0;
        for (int b = WB - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                pos = gba_pkg::WORD_SHIFT'(b);
            end
        end
    end

    assign idx_bit_mask = WB'(1) << idx_reg[gba_pkg::WORD_SHIFT-1:0];

    // saturating counter updates
    always_comb
    begin
        used_inc = {1'b0, gu_rdata_reg} + (IPG_W+1)'(1);
        tot_inc  = {1'b0, total_reg} + (TOT_W+1)'(1);
        if (set_reg)
        begin
            used_new = (used_inc >= {1'b0, eff_ipg}) ? eff_ipg : IPG_W'(used_inc);
            tot_new  = (tot_inc >= {1'b0, cap}) ? cap : TOT_W'(tot_inc);
        end
        else
        begin
            used_new = (gu_rdata_reg != '0) ? gu_rdata_reg - IPG_W'(1) : '0;
            tot_new  = (total_reg != '0) ? total_reg - TOT_W'(1) : '0;
        end
    end

    assign g_ok_in = 32'(cmd.group) < 32'(eff_groups);

    always_comb
    begin
        if (32'(g_reg) < GROUPS && eff_ipg > gu_rdata_reg)
        begin
            fig_full = eff_ipg - gu_rdata_reg;
        end
        else
        begin
            fig_full = '0;
        end
        ft_full = (cap > total_reg) ? cap - total_reg : '0;
        nsum    = SUM_W'(prod_reg) + SUM_W'(idx_reg) + SUM_W'(base);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        op_next        = op_reg;
        g_next         = g_reg;
        w_next         = w_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        set_next       = set_reg;
        status_next    = status_reg;
        gout_next      = gout_reg;
        total_next     = total_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        bm_we     = 1'b0;
        bm_waddr  = {GRP_W'(g_reg), w_reg};
        bm_wdata  = bm_rdata;
        bm_raddr  = {GRP_W'(g_reg), w_reg};
        gu_we     = 1'b0;
        gu_waddr  = GRP_W'(g_reg);
        gu_wdata  = used_new;
        gu_raddr  = GRP_W'(g_reg);
        mod_start = 1'b0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                bm_we        = 1'b1;
                bm_waddr     = clr_cnt_reg;
                bm_wdata     = '0;
                gu_we        = 1'b1;
                gu_waddr     = clr_cnt_reg[GRP_W-1:0];
                gu_wdata     = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                bm_raddr = {GRP_W'(cmd.group), WIDX_W'(0)};
                gu_raddr = (cmd.op == gba_pkg::OP_FIND) ? '0 : GRP_W'(cmd.group);
                if (cmd_valid)
                begin
                    op_next     = cmd.op;
                    g_next      = cmd.group;
                    w_next      = '0;
                    k_next      = '0;
                    status_next = 1'b0;
                    gout_next   = '0;
                    set_next    = (cmd.op == gba_pkg::OP_MARK);
                    case (cmd.op)
                        gba_pkg::OP_ALLOC:
                        begin
                            set_next = 1'b1;
                            if (g_ok_in)
                            begin
                                state_next = ST_ALLOC;
                            end
                            else
                            begin
                                status_next = 1'b1;
                                state_next  = ST_FIN;
                            end
                        end
                        gba_pkg::OP_FIND:
                        begin
                            state_next = ST_FIND;
                        end
                        gba_pkg::OP_RELEASE, gba_pkg::OP_MARK:
                        begin
                            if (g_ok_in && cmd.item_number >= gba_pkg::NUM_W'(base))
                            begin
                                mod_start  = 1'b1;
                                state_next = ST_MOD;
                            end
                            else
                            begin
                                status_next = 1'b1;
                                state_next  = ST_FIN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ALLOC:
            begin
                // prefetch the next word while this one is checked
                bm_raddr = {GRP_W'(g_reg), w_reg + WIDX_W'(1)};
                if (found)
                begin
                    bm_we      = 1'b1;
                    bm_wdata   = bm_rdata | (WB'(1) << pos);
                    idx_next   = {w_reg, pos};
                    state_next = ST_CNT;
                end
                else if (w_reg == last_word)
                begin
                    status_next = 1'b1;
                    state_next  = ST_FIN;
                end
                else
                begin
                    w_next = w_reg + WIDX_W'(1);
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    idx_next   = IDX_W'(mod_rem);
                    state_next = ST_RMW_RD;
                end
            end
            ST_RMW_RD:
            begin
                bm_raddr   = {GRP_W'(g_reg), idx_reg[IDX_W-1:gba_pkg::WORD_SHIFT]};
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR:
            begin
                bm_we    = 1'b1;
                bm_waddr = {GRP_W'(g_reg), idx_reg[IDX_W-1:gba_pkg::WORD_SHIFT]};
                bm_wdata = set_reg ? (bm_rdata | idx_bit_mask) : (bm_rdata & ~idx_bit_mask);
                state_next = ST_CNT;
            end
            ST_FIND:
            begin
                gu_raddr = GRP_W'(k_reg + GCNT_W'(1));
                if (gu_rdata_reg < eff_ipg)
                begin
                    gout_next  = gba_pkg::GRP_IN_W'(k_reg);
                    state_next = ST_FIN;
                end
                else if (k_reg + GCNT_W'(1) == eff_groups)
                begin
                    status_next = 1'b1;
                    state_next  = ST_FIN;
                end
                else
                begin
                    k_next = k_reg + GCNT_W'(1);
                end
            end
            ST_CNT:
            begin
                gu_we      = 1'b1;
                total_next = tot_new;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // counter of the addressed group, fresh after the update
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next         = 1'b1;
                    res_next.status        = status_reg;
                    res_next.number_out    = (op_reg == gba_pkg::OP_ALLOC && !status_reg)
                                           ? gba_pkg::NUM_W'(nsum) : '0;
                    res_next.group_out     = gout_reg;
                    res_next.free_in_group = gba_pkg::FIG_W'(fig_full);
                    res_next.free_total    = gba_pkg::FT_W'(ft_full);
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            op_reg        <= '0;
            g_reg         <= '0;
            w_reg         <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            set_reg       <= 1'b0;
            status_reg    <= 1'b0;
            gout_reg      <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            op_reg        <= op_next;
            g_reg         <= g_next;
            w_reg         <= w_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            set_reg       <= set_next;
            status_reg    <= status_next;
            gout_reg      <= gout_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    // group base of the allocated number, registered from the latched group
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(g_reg) * PROD_W'(eff_ipg);
    end

    always_ff @(posedge clk)
    begin
        if (gu_we)
        begin
            gu_mem[gu_waddr] <= gu_wdata;
        end
        gu_rdata_reg <= gu_mem[gu_raddr];
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC && found) |-> ({1'b0, w_reg, pos} < eff_ipg))
        else $error("allocated index beyond group size");

    a_group_used_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CNT && set_reg) |-> gu_wdata <= eff_ipg)
        else $error("group counter above group size");

    a_total_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CNT && set_reg) |=> total_reg <= cap)
        else $error("total counter above capacity");

endmodule

// ===== rtl/core/grouped_bitmap_allocator_core.sv =====
// top level: configuration registers, derived limits and the operation sequencer
//
//  channel  dir  handshake             payload
//  cmd      in   cmd_valid/cmd_stall   op, group, item_number
//  res      out  res_valid/res_stall   status, number_out, group_out, free_in_group, free_total
//  cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
//  from accept to res_valid: allocate scans the bitmap words in turn, release and mark
//  run the 19-step remainder unit and then read and write the word, find free group checks
//  the group counters in turn, and any rejected request goes straight to the result
//  cmd_stall falls on the same edge that raises res_valid
//  after reset a clearing pass over every bitmap word keeps cmd_stall high
//  a stalled result holds the output register; the next cmd beat is still taken
module grouped_bitmap_allocator_core #(
    parameter int GROUPS     = gba_pkg::DEF_GROUPS,
    parameter int GROUP_BITS = gba_pkg::DEF_GROUP_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  gba_pkg::cmd_item_t                cmd,
    output logic                              res_valid,
    input  logic                              res_stall,
    output gba_pkg::res_item_t                res,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gba_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int WPG    = GROUP_BITS / gba_pkg::WORD_BITS;
    localparam int WIDX_W = $clog2(WPG);
    localparam int IPG_W  = $clog2(GROUP_BITS + 1);
    localparam int IDX_W  = WIDX_W + gba_pkg::WORD_SHIFT;
    localparam int GCNT_W = $clog2(GROUPS + 1);
    localparam int TOT_W  = $clog2(GROUPS * GROUP_BITS + 1);

    logic [gba_pkg::IPG_CFG_W-1:0]  ipg_cfg_reg;
    logic [gba_pkg::GCNT_CFG_W-1:0] gcnt_cfg_reg;
    logic                           base_cfg_reg;

    logic [IPG_W-1:0]               eff_ipg;
    logic [GCNT_W-1:0]              eff_groups;
    logic [IPG_W-1:0]               ipg_m1;
    logic [TOT_W-1:0]               cap_reg;
    logic [WIDX_W-1:0]              last_word_reg;
    logic [gba_pkg::WORD_BITS-1:0]  last_mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipg_cfg_reg  <= gba_pkg::DEF_IPG;
            gcnt_cfg_reg <= gba_pkg::DEF_GCNT;
            base_cfg_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gba_pkg::CFG_IPG:  ipg_cfg_reg  <= cfg_data[gba_pkg::IPG_CFG_W-1:0];
                gba_pkg::CFG_GCNT: gcnt_cfg_reg <= cfg_data[gba_pkg::GCNT_CFG_W-1:0];
                gba_pkg::CFG_BASE: base_cfg_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // zero reads as one, oversize reads as the built-in limit
    always_comb
    begin
        if (ipg_cfg_reg == '0)
        begin
            eff_ipg = IPG_W'(1);
        end
        else if (32'(ipg_cfg_reg) > 32'(GROUP_BITS))
        begin
            eff_ipg = IPG_W'(GROUP_BITS);
        end
        else
        begin
            eff_ipg = IPG_W'(ipg_cfg_reg);
        end

        if (gcnt_cfg_reg == '0)
        begin
            eff_groups = GCNT_W'(1);
        end
        else if (32'(gcnt_cfg_reg) > 32'(GROUPS))
        begin
            eff_groups = GCNT_W'(GROUPS);
        end
        else
        begin
            eff_groups = GCNT_W'(gcnt_cfg_reg);
        end
    end

    assign ipg_m1 = eff_ipg - IPG_W'(1);

    // capacity, last word and last-word mask are registered from the effective settings
    always_ff @(posedge clk)
    begin
        cap_reg       <= TOT_W'(eff_groups) * TOT_W'(eff_ipg);
        last_word_reg <= ipg_m1[IDX_W-1:gba_pkg::WORD_SHIFT];
        last_mask_reg <= ~({gba_pkg::WORD_BITS{1'b1}} << 1
                           << ipg_m1[gba_pkg::WORD_SHIFT-1:0]);
    end

    gba_seq #(
        .GROUPS     (GROUPS),
        .GROUP_BITS (GROUP_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .eff_ipg    (eff_ipg),
        .eff_groups (eff_groups),
        .base       (base_cfg_reg),
        .cap        (cap_reg),
        .last_word  (last_word_reg),
        .last_mask  (last_mask_reg)
    );

endmodule

// ===== verif/tb_grouped_bitmap_allocator_core.sv =====
`timescale 1ns / 100ps
// self-checking testbench of grouped_bitmap_allocator_core against a bitmap mirror
module tb_grouped_bitmap_allocator_core;

    localparam int N_GROUPS = gba_pkg::DEF_GROUPS;
    localparam int N_BITS   = gba_pkg::DEF_GROUP_BITS;
    localparam int MAX_DATA = (1 << gba_pkg::CFG_DATA_W) - 1;
    localparam int MAX_NUM  = (1 << gba_pkg::NUM_W) - 1;
    localparam logic [gba_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // mirror of the bitmaps, counters and registers, plus the results still owed
    class alloc_mirror;
        logic [gba_pkg::IPG_CFG_W-1:0]  ipg_reg;
        logic [gba_pkg::GCNT_CFG_W-1:0] gcnt_reg;
        logic                           base_reg;
        bit                             used_map [N_GROUPS][N_BITS];
        int unsigned                    grp_used [N_GROUPS];
        int unsigned                    tot_used;
        gba_pkg::res_item_t             pending_res [$];
        int unsigned                    n_cmds;
        int unsigned                    n_res;
        int unsigned                    n_errors;

        function new();
            ipg_reg  = gba_pkg::DEF_IPG;
            gcnt_reg = gba_pkg::DEF_GCNT;
            base_reg = 1'b0;
            tot_used = 0;
            n_cmds   = 0;
            n_res    = 0;
            n_errors = 0;
            foreach (grp_used[k])
                grp_used[k] = 0;
        endfunction

        function int unsigned eff_ipg();
            if (ipg_reg == 0)
                return 1;
            if (ipg_reg > N_BITS)
                return N_BITS;
            return 32'(ipg_reg);
        endfunction

        function int unsigned eff_groups();
            if (gcnt_reg == 0)
                return 1;
            if (gcnt_reg > N_GROUPS)
                return N_GROUPS;
            return 32'(gcnt_reg);
        endfunction

        function void set_reg(logic [gba_pkg::CFG_IDX_W-1:0] idx,
                              logic [gba_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                gba_pkg::CFG_IPG:  ipg_reg  = data[gba_pkg::IPG_CFG_W-1:0];
                gba_pkg::CFG_GCNT: gcnt_reg = data[gba_pkg::GCNT_CFG_W-1:0];
                gba_pkg::CFG_BASE: base_reg = data[0];
                default:  ;
            endcase
        endfunction

        // counters move on every write, even when the bit already held the value
        function void put_bit(int unsigned g, int unsigned idx, bit val);
            int unsigned ipg;
            int unsigned cap;
            ipg = eff_ipg();
            cap = eff_groups() * ipg;
            used_map[g][idx] = val;
            if (val)
            begin
                grp_used[g] = (grp_used[g] + 1 >= ipg) ? ipg : grp_used[g] + 1;
                tot_used    = (tot_used + 1 >= cap) ? cap : tot_used + 1;
            end
            else
            begin
                if (grp_used[g] > 0)
                    grp_used[g]--;
                if (tot_used > 0)
                    tot_used--;
            end
        endfunction

        function void apply_cmd(gba_pkg::cmd_item_t c);
            gba_pkg::res_item_t r;
            int unsigned        ipg;
            int unsigned        act;
            int unsigned        g;
            int unsigned        idx;
            int unsigned        cap;
            bit                 g_ok;
            ipg  = eff_ipg();
            act  = eff_groups();
            g    = 32'(c.group);
            g_ok = g < act;
            r    = '0;
            n_cmds++;
            case (c.op)
                gba_pkg::OP_ALLOC:
                begin
                    // first fit over the bits, ignoring the counters
                    idx = 0;
                    if (g_ok)
                        while (idx < ipg && used_map[g][idx])
                            idx++;
                    if (g_ok && idx < ipg)
                    begin
                        put_bit(g, idx, 1'b1);
                        r.number_out = gba_pkg::NUM_W'(g * ipg + idx + 32'(base_reg));
                    end
                    else
                        r.status = 1'b1;
                end
                gba_pkg::OP_FIND:
                begin
                    // trusts the counters, not the bits
                    r.status = 1'b1;
                    for (int k = 0; k < act; k++)
                    begin
                        if (grp_used[k] < ipg)
                        begin
                            r.group_out = gba_pkg::GRP_IN_W'(k);
                            r.status    = 1'b0;
                            break;
                        end
                    end
                end
                default:
                begin
                    if (!g_ok || c.item_number < base_reg)
                        r.status = 1'b1;
                    else
                        put_bit(g, (32'(c.item_number) - 32'(base_reg)) % ipg,
                                c.op == gba_pkg::OP_MARK);
                end
            endcase
            cap = act * ipg;
            r.free_in_group = gba_pkg::FIG_W'((ipg > grp_used[g]) ? ipg - grp_used[g] : 0);
            r.free_total    = gba_pkg::FT_W'((cap > tot_used) ? cap - tot_used : 0);
            pending_res.push_back(r);
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                n_errors++;
            end
        endfunction

        function void check_res(gba_pkg::res_item_t got);
            gba_pkg::res_item_t want;
            n_res++;
            if (pending_res.size() == 0)
            begin
                $display("%0t: result beat with nothing outstanding, got %h", $time, got);
                n_errors++;
                return;
            end
            want = pending_res.pop_front();
            cmp_field("status", 32'(want.status), 32'(got.status));
            cmp_field("number_out", 32'(want.number_out), 32'(got.number_out));
            cmp_field("group_out", 32'(want.group_out), 32'(got.group_out));
            cmp_field("free_in_group", 32'(want.free_in_group), 32'(got.free_in_group));
            cmp_field("free_total", 32'(want.free_total), 32'(got.free_total));
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cmd_valid;
    logic                           cmd_stall;
    gba_pkg::cmd_item_t             cmd;
    logic                           res_valid;
    logic                           res_stall;
    gba_pkg::res_item_t             res;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [gba_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gba_pkg::CFG_DATA_W-1:0] cfg_data;

    alloc_mirror sb;
    bit          quiet;
    int unsigned n_settings;

    grouped_bitmap_allocator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one, none in quiet phases
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 55)
            return 0;
        if (r < 85)
            return int'($urandom_range(1, 3));
        if (r < 97)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic gba_pkg::cmd_item_t mk(logic [gba_pkg::OP_W-1:0] op, int unsigned g,
                                              int unsigned num);
        gba_pkg::cmd_item_t c;
        c.op          = op;
        c.group       = gba_pkg::GRP_IN_W'(g);
        c.item_number = gba_pkg::NUM_W'(num);
        return c;
    endfunction

    // entered and left at a falling edge
    task automatic send_cmd(gba_pkg::cmd_item_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (sb.pending_res.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [gba_pkg::CFG_IDX_W-1:0] idx, int unsigned data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= gba_pkg::CFG_DATA_W'(data);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic do_cfg(input int unsigned ipg_d, gcnt_d, base_d, input bit spare);
        write_reg(gba_pkg::CFG_IPG, ipg_d);
        write_reg(gba_pkg::CFG_GCNT, gcnt_d);
        write_reg(gba_pkg::CFG_BASE, base_d);
        if (spare)
            write_reg(CFG_SPARE, $urandom_range(0, MAX_DATA));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                sb.check_res(res);
            if (cmd_valid && !cmd_stall)
                sb.apply_cmd(cmd);
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        res_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                res_stall <= 1'b0;
                if ($urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        gba_pkg::cmd_item_t c;
        int unsigned        ipg;
        int unsigned        act;
        int unsigned        g;
        int unsigned        idx;
        int unsigned        r;
        int unsigned        lim;
        int unsigned        ipg_d;
        int unsigned        gcnt_d;
        cmd_valid  = 1'b0;
        cmd        = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        quiet      = 1'b0;
        n_settings = 0;
        sb         = new();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: 8192 per group, 32 groups, numbers from 0
        send_cmd(mk(gba_pkg::OP_ALLOC, 0, 0));
        send_cmd(mk(gba_pkg::OP_ALLOC, 31, 0));
        send_cmd(mk(gba_pkg::OP_MARK, 31, MAX_NUM));
        send_cmd(mk(gba_pkg::OP_RELEASE, 31, 31 * N_BITS));
        send_cmd(mk(gba_pkg::OP_RELEASE, 5, 0));
        send_cmd(mk(gba_pkg::OP_FIND, 0, 0));
        send_cmd(mk(gba_pkg::OP_ALLOC, 31, 0));
        drain();

        // tiny groups: fill them, find nothing, reject inactive group and low number
        do_cfg(2, 2, 1, 1'b1);
        send_cmd(mk(gba_pkg::OP_ALLOC, 0, 0));
        send_cmd(mk(gba_pkg::OP_ALLOC, 0, 0));
        send_cmd(mk(gba_pkg::OP_ALLOC, 0, 0));
        send_cmd(mk(gba_pkg::OP_FIND, 0, 0));
        send_cmd(mk(gba_pkg::OP_ALLOC, 1, 0));
        send_cmd(mk(gba_pkg::OP_MARK, 1, 4));
        send_cmd(mk(gba_pkg::OP_FIND, 0, 0));
        send_cmd(mk(gba_pkg::OP_ALLOC, 2, 0));
        send_cmd(mk(gba_pkg::OP_RELEASE, 0, 0));
        send_cmd(mk(gba_pkg::OP_MARK, 0, 1));
        send_cmd(mk(gba_pkg::OP_RELEASE, 1, MAX_NUM));
        send_cmd(mk(gba_pkg::OP_FIND, 0, 0));
        drain();

        // zero registers read as one; counters now above the group size
        do_cfg(0, 0, 0, 1'b0);
        send_cmd(mk(gba_pkg::OP_ALLOC, 0, 0));
        send_cmd(mk(gba_pkg::OP_RELEASE, 0, 7));
        send_cmd(mk(gba_pkg::OP_ALLOC, 0, 0));
        drain();

        // oversize registers clip to the store size
        do_cfg(MAX_DATA, 63, 0, 1'b0);
        send_cmd(mk(gba_pkg::OP_ALLOC, 31, 0));
        send_cmd(mk(gba_pkg::OP_FIND, 0, 0));
        send_cmd(mk(gba_pkg::OP_MARK, 17, 1 << (gba_pkg::NUM_W - 1)));
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(0, 6))
                0:       ipg_d = 0;
                1:       ipg_d = 1;
                2:       ipg_d = $urandom_range(2, 8);
                3:       ipg_d = $urandom_range(9, 70);
                4:       ipg_d = N_BITS;
                5:       ipg_d = $urandom_range(N_BITS + 1, MAX_DATA);
                default: ipg_d = $urandom_range(71, 3000);
            endcase
            case ($urandom_range(0, 5))
                0:       gcnt_d = 0;
                1:       gcnt_d = 1;
                2:       gcnt_d = $urandom_range(2, 5);
                3:       gcnt_d = N_GROUPS;
                4:       gcnt_d = $urandom_range(N_GROUPS + 1, 63);
                default: gcnt_d = $urandom_range(0, MAX_DATA);
            endcase
            do_cfg(ipg_d, gcnt_d, $urandom_range(0, MAX_DATA), $urandom_range(0, 3) == 0);
            quiet = ($urandom_range(0, 3) == 0);
            ipg   = sb.eff_ipg();
            act   = sb.eff_groups();
            lim   = (ipg < 64) ? ipg : 64;
            repeat (100)
            begin
                // mostly sane numbers near the bottom of an active group
                r   = $urandom_range(0, 99);
                g   = ($urandom_range(0, 99) < 85) ? $urandom_range(0, act - 1)
                                                   : $urandom_range(0, N_GROUPS - 1);
                idx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, lim - 1)
                                                  : $urandom_range(0, ipg - 1);
                c = mk(gba_pkg::OP_ALLOC, g, g * ipg + idx + 32'(sb.base_reg));
                if (r >= 35 && r < 60)
                    c.op = gba_pkg::OP_RELEASE;
                else if (r >= 60 && r < 72)
                    c.op = gba_pkg::OP_FIND;
                else if (r >= 72 && r < 87)
                    c.op = gba_pkg::OP_MARK;
                else if (r >= 87)
                begin
                    c = mk(gba_pkg::OP_W'($urandom_range(0, 3)),
                           $urandom_range(0, N_GROUPS - 1), $urandom_range(0, MAX_NUM));
                    if ($urandom_range(0, 3) == 0)
                        c.item_number = '0;
                end
                send_cmd(c);
            end
            drain();
        end
        quiet = 1'b1;

        // anything arriving now is a stray beat
        repeat (300) @(negedge clk);
        $display("%0d commands over %0d register settings, %0d results checked",
                 sb.n_cmds, n_settings + 1, sb.n_res);
        $display("%0d items still in use, %0d mismatches", sb.tot_used, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending_res.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
